/* rtl/core/min_max_pixel_rescale_defines.svh */
// Assertion macros shared by the min/max pixel rescale RTL.
// Included by mmpr_back, the one module that carries concurrent checks; no other dependencies.
`ifndef MIN_MAX_PIXEL_RESCALE_DEFINES_SVH
`define MIN_MAX_PIXEL_RESCALE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define MMPR_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mmpr implication check failed");
// Next-cycle implication, disabled during reset
`define MMPR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mmpr next-cycle check failed");
`else
`define MMPR_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define MMPR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* rtl/core/mmpr_pkg.sv */
// Types and constants for the min/max pixel rescale block.
// Used by mmpr_front, mmpr_queue, mmpr_back and min_max_pixel_rescale.
`default_nettype none

package mmpr_pkg;

    localparam logic [15:0] FULL_NARROW = 16'd255;
    localparam logic [15:0] FULL_WIDE   = 16'd65535;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS = 16;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // How the back end finishes a convert word
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ZERO,
        KIND_FULL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;   // pixel for pass-through, p - min for divide
        logic [15:0] span;    // max - min for divide
    } job_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_CALC,
        B_FINISH
    } bstate_t;

endpackage

`default_nettype wire

/* rtl/core/mmpr_front.sv */
// Front end: accepts words, tracks frame min/max, classifies converts.
// Depends on mmpr_pkg; pushes jobs into mmpr_queue.
`default_nettype none

module mmpr_front #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          action,
    input  wire logic          first_of_frame,
    input  wire logic [15:0]   pixel_in,
    output logic               push_valid,
    input  wire logic          push_ready,
    output mmpr_pkg::job_t     push_job
);

    localparam logic [15:0] SRC_MASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;
    logic [15:0] pix;
    logic        accept;

    assign pix      = pixel_in & SRC_MASK;
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Track min/max on measure words
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept && !action) begin
            if (first_of_frame) begin
                min_next = pix;
                max_next = pix;
            end else begin
                if (pix < min_reg) min_next = pix;
                if (pix > max_reg) max_next = pix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_reg <= SRC_MASK;
            max_reg <= 16'd0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // Classify convert words against the stored range
    always_comb
    begin
        push_job.value = 16'(pix - min_reg);
        push_job.span  = 16'(max_reg - min_reg);
        if (max_reg <= min_reg) begin
            push_job.kind  = mmpr_pkg::KIND_PASS;
            push_job.value = pix;
        end else if (pix <= min_reg) begin
            push_job.kind = mmpr_pkg::KIND_ZERO;
        end else if (pix >= max_reg) begin
            push_job.kind = mmpr_pkg::KIND_FULL;
        end else begin
            push_job.kind = mmpr_pkg::KIND_DIV;
        end
    end

    assign push_valid = accept && action;

endmodule

`default_nettype wire

/* rtl/core/mmpr_queue.sv */
// Short job queue between front and back end, held in flops.
// Depends on mmpr_pkg for the job type and depth.
`default_nettype none

module mmpr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mmpr_pkg::job_t push_job,
    output logic                pop_valid,
    input  wire logic           pop,
    output mmpr_pkg::job_t      pop_job
);

    mmpr_pkg::job_t                  slots [mmpr_pkg::QUEUE_DEPTH];
    logic [mmpr_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mmpr_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mmpr_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign push_ready = count_reg != mmpr_pkg::QCNT_W'(mmpr_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == mmpr_pkg::QPTR_W'(mmpr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : mmpr_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == mmpr_pkg::QPTR_W'(mmpr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : mmpr_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = mmpr_pkg::QCNT_W'(count_reg + 1'b1);
        end else if (!do_push && do_pop) begin
            count_next = mmpr_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mmpr_back.sv */
// Back end: finishes convert jobs with a radix-2 restoring divider and
// holds the result word. Depends on mmpr_pkg and the assertion macros.
`default_nettype none
`include "min_max_pixel_rescale_defines.svh"

module mmpr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           target_is_wide,
    input  wire logic           job_valid,
    output logic                pop,
    input  wire mmpr_pkg::job_t job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [15:0]         pixel_out
);

    mmpr_pkg::bstate_t             state_reg, state_next;
    logic [mmpr_pkg::DCNT_W-1:0]   cnt_reg;
    logic [15:0]                   rem_reg;
    logic [15:0]                   low_reg;
    logic [15:0]                   span_reg;
    logic                          out_valid_reg;
    logic [15:0]                   pixel_out_reg;
    logic                          slot_free;
    logic                          out_load;
    logic [15:0]                   out_value;
    logic [15:0]                   full;
    logic [31:0]                   numer;
    logic [16:0]                   trial;
    logic                          fits;
    logic [16:0]                   diff17;

    assign full      = target_is_wide ? mmpr_pkg::FULL_WIDE : mmpr_pkg::FULL_NARROW;
    assign slot_free = !out_valid_reg || out_ready;

    // full * (p - min) as shift and subtract
    assign numer = target_is_wide
                   ? ({low_reg, 16'd0} - {16'd0, low_reg})
                   : ({8'd0, low_reg, 8'd0} - {16'd0, low_reg});

    // One restoring step
    assign trial  = {rem_reg, low_reg[15]};
    assign diff17 = trial - {1'b0, span_reg};
    assign fits   = trial >= {1'b0, span_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmpr_pkg::B_IDLE:
            begin
                if (job_valid && job.kind == mmpr_pkg::KIND_DIV) begin
                    state_next = mmpr_pkg::B_SETUP;
                end
            end
            mmpr_pkg::B_SETUP:
            begin
                state_next = mmpr_pkg::B_CALC;
            end
            mmpr_pkg::B_CALC:
            begin
                if (cnt_reg == mmpr_pkg::DCNT_W'(mmpr_pkg::DIV_STEPS - 1)) begin
                    state_next = mmpr_pkg::B_FINISH;
                end
            end
            mmpr_pkg::B_FINISH:
            begin
                if (slot_free) begin
                    state_next = mmpr_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mmpr_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: pop, result load
    always_comb
    begin
        pop       = 1'b0;
        out_load  = 1'b0;
        out_value = low_reg;
        case (state_reg)
            mmpr_pkg::B_IDLE:
            begin
                if (job_valid) begin
                    case (job.kind)
                        mmpr_pkg::KIND_DIV:
                        begin
                            pop = 1'b1;
                        end
                        mmpr_pkg::KIND_ZERO:
                        begin
                            pop       = slot_free;
                            out_load  = slot_free;
                            out_value = 16'd0;
                        end
                        mmpr_pkg::KIND_FULL:
                        begin
                            pop       = slot_free;
                            out_load  = slot_free;
                            out_value = full;
                        end
                        default:
                        begin
                            pop       = slot_free;
                            out_load  = slot_free;
                            out_value = job.value & full;
                        end
                    endcase
                end
            end
            mmpr_pkg::B_FINISH:
            begin
                out_load = slot_free;
            end
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= mmpr_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider datapath: load, set up numerator, shift quotient in
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mmpr_pkg::B_IDLE:
            begin
                low_reg  <= job.value;
                span_reg <= job.span;
                cnt_reg  <= '0;
            end
            mmpr_pkg::B_SETUP:
            begin
                rem_reg <= numer[31:16];
                low_reg <= numer[15:0];
                cnt_reg <= '0;
            end
            mmpr_pkg::B_CALC:
            begin
                rem_reg <= fits ? diff17[15:0] : trial[15:0];
                low_reg <= {low_reg[14:0], fits};
                cnt_reg <= mmpr_pkg::DCNT_W'(cnt_reg + 1'b1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
        if (out_load) begin
            pixel_out_reg <= out_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    // Checks
    `MMPR_ASSERT_IMPLIES(a_rem_below_span, clk, rst_n, state_reg == mmpr_pkg::B_CALC, rem_reg < span_reg)
    `MMPR_ASSERT_IMPLIES(a_pop_only_idle, clk, rst_n, pop, state_reg == mmpr_pkg::B_IDLE)
    `MMPR_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !out_load)
    `MMPR_ASSERT_NEXT(a_calc_starts_clean, clk, rst_n, state_reg == mmpr_pkg::B_SETUP, state_reg == mmpr_pkg::B_CALC && cnt_reg == '0)

endmodule

`default_nettype wire

/* rtl/core/min_max_pixel_rescale.sv */
// Top level of the min/max pixel rescale block: config register and
// wiring of mmpr_front, mmpr_queue and mmpr_back. Depends on mmpr_pkg.
//
//  Channel   Signals                                   Handshake
//  -------   ---------------------------------------   ---------------
//  in        action, first_of_frame, pixel_in          in_valid/in_ready
//  out       pixel_out                                 out_valid/out_ready
//  cfg       cfg_wr_data (target_is_wide)              cfg_wr_en, no wait
//
//  Measure words end in the front at accept; a convert with no divide is popped
//  and loaded in the back-end idle state once the output slot is free. A divided
//  convert runs pop, numerator setup, 16 radix-2 quotient steps and result load,
//  which waits for a free output slot. A two-deep job queue lets the front keep
//  taking words while the divider runs or a result waits; in_ready drops only
//  when the queue is full. Reset: min = 2^PIXEL_BITS - 1, max = 0, narrow target.
`default_nettype none

module min_max_pixel_rescale #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic        first_of_frame,
    input  wire logic [15:0] pixel_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      pixel_out,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data
);

    logic           target_is_wide_reg;
    logic           push_valid, push_ready;
    mmpr_pkg::job_t push_job;
    logic           job_valid, pop;
    mmpr_pkg::job_t job;

    // Hold the target width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_is_wide_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            target_is_wide_reg <= cfg_wr_data;
        end
    end

    mmpr_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .first_of_frame (first_of_frame),
        .pixel_in       (pixel_in),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_job       (push_job)
    );

    mmpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop        (pop),
        .pop_job    (job)
    );

    mmpr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .target_is_wide (target_is_wide_reg),
        .job_valid      (job_valid),
        .pop            (pop),
        .job            (job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_out      (pixel_out)
    );

endmodule

`default_nettype wire
